FILE: src/tmp_pkg.sv
package tmp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PC_W          = 6;
  localparam int REG_W         = 5;
  localparam int REG_DEPTH     = 32;
  localparam int LOAD_N        = 9;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL   = 2'd1;

  typedef logic [REG_W-1:0] reg_addr_t;
  typedef logic [PC_W-1:0]  pc_t;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MIN, OP_HALF, OP_NEG, OP_ADD2, OP_MUL, OP_DIV, OP_SQRT,
    OP_JZ, OP_JGE, OP_JNTRI, OP_JMP, OP_END2, OP_END3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_FETCH, S_EXEC, S_MULW, S_WAIT, S_EMIT
  } state_t;

  // scratch register map
  localparam reg_addr_t R_SP   = 5'd0;
  localparam reg_addr_t R_ST   = 5'd1;
  localparam reg_addr_t R_SV   = 5'd2;
  localparam reg_addr_t R_EV   = 5'd3;
  localparam reg_addr_t R_D    = 5'd4;
  localparam reg_addr_t R_TS   = 5'd5;
  localparam reg_addr_t R_MA   = 5'd6;
  localparam reg_addr_t R_MV   = 5'd7;
  localparam reg_addr_t R_ACC  = 5'd8;
  localparam reg_addr_t R_VC   = 5'd9;
  localparam reg_addr_t R_DV   = 5'd10;
  localparam reg_addr_t R_AI   = 5'd11;
  localparam reg_addr_t R_AD   = 5'd12;
  localparam reg_addr_t R_CD   = 5'd13;
  localparam reg_addr_t R_CI   = 5'd14;
  localparam reg_addr_t R_T0   = 5'd15;
  localparam reg_addr_t R_T1   = 5'd16;
  localparam reg_addr_t R_DEC  = 5'd17;
  localparam reg_addr_t R_DI   = 5'd18;
  localparam reg_addr_t R_DD   = 5'd19;
  localparam reg_addr_t R_TTC  = 5'd20;
  localparam reg_addr_t R_APOS = 5'd21;
  localparam reg_addr_t R_CP   = 5'd22;
  localparam reg_addr_t R_CT   = 5'd23;
  localparam reg_addr_t R_FP   = 5'd24;
  localparam reg_addr_t R_FT   = 5'd25;
  localparam reg_addr_t R_TOT  = 5'd26;

  localparam pc_t L_BIG   = 6'd20;
  localparam pc_t L_AFTER = 6'd32;
  localparam pc_t L_TRAP  = 6'd52;

  typedef struct packed {
    op_t       op;
    reg_addr_t dst;
    reg_addr_t a;
    reg_addr_t b;
    pc_t       tgt;
  } instr_t;

  typedef struct packed {
    logic signed [31:0] sp;
    logic signed [31:0] st;
    logic signed [31:0] sv;
    logic signed [31:0] ev;
    logic signed [31:0] d;
    logic signed [31:0] ts;
    logic               rev;
  } req_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return v[31:0];
  endfunction

  function automatic instr_t mk(input op_t op, input reg_addr_t dst, input reg_addr_t a,
                                input reg_addr_t b, input pc_t tgt);
    instr_t i;
    i.op = op; i.dst = dst; i.a = a; i.b = b; i.tgt = tgt;
    return i;
  endfunction

  // planner program
  function automatic instr_t prog(input pc_t pc);
    case (pc)
      6'd0:  return mk(OP_MUL,   R_T0,   R_D,    R_ACC, '0);
      6'd1:  return mk(OP_SQRT,  R_T0,   R_T0,   R_T0,  '0);
      6'd2:  return mk(OP_MIN,   R_VC,   R_T0,   R_MV,  '0);
      6'd3:  return mk(OP_JZ,    R_T0,   R_TS,   R_TS,  L_AFTER);
      6'd4:  return mk(OP_SUB,   R_DV,   R_VC,   R_SV,  '0);
      6'd5:  return mk(OP_DIV,   R_AI,   R_DV,   R_ACC, '0);
      6'd6:  return mk(OP_ADD,   R_T0,   R_SV,   R_VC,  '0);
      6'd7:  return mk(OP_MUL,   R_T0,   R_T0,   R_AI,  '0);
      6'd8:  return mk(OP_HALF,  R_AD,   R_T0,   R_T0,  '0);
      6'd9:  return mk(OP_ADD,   R_T0,   R_AD,   R_AD,  '0);
      6'd10: return mk(OP_SUB,   R_CD,   R_D,    R_T0,  '0);
      6'd11: return mk(OP_DIV,   R_CI,   R_CD,   R_VC,  '0);
      6'd12: return mk(OP_ADD,   R_T0,   R_AI,   R_AI,  '0);
      6'd13: return mk(OP_ADD,   R_T0,   R_CI,   R_T0,  '0);
      6'd14: return mk(OP_JGE,   R_T0,   R_T0,   R_TS,  L_AFTER);
      6'd15: return mk(OP_JNTRI, R_T0,   R_CD,   R_CD,  L_BIG);
      6'd16: return mk(OP_HALF,  R_T0,   R_TS,   R_TS,  '0);
      6'd17: return mk(OP_DIV,   R_T0,   R_DV,   R_T0,  '0);
      6'd18: return mk(OP_MIN,   R_ACC,  R_T0,   R_MA,  '0);
      6'd19: return mk(OP_JMP,   R_T0,   R_T0,   R_T0,  L_AFTER);
      6'd20: return mk(OP_DIV,   R_T0,   R_CI,   R_AI,  '0);
      6'd21: return mk(OP_ADD2,  R_T0,   R_T0,   R_T0,  '0);
      6'd22: return mk(OP_DIV,   R_AI,   R_TS,   R_T0,  '0);
      6'd23: return mk(OP_ADD,   R_T0,   R_AI,   R_AI,  '0);
      6'd24: return mk(OP_SUB,   R_CI,   R_TS,   R_T0,  '0);
      6'd25: return mk(OP_ADD,   R_T0,   R_D,    R_D,   '0);
      6'd26: return mk(OP_ADD,   R_T1,   R_TS,   R_CI,  '0);
      6'd27: return mk(OP_DIV,   R_T0,   R_T0,   R_T1,  '0);
      6'd28: return mk(OP_MIN,   R_VC,   R_T0,   R_MV,  '0);
      6'd29: return mk(OP_SUB,   R_DV,   R_VC,   R_SV,  '0);
      6'd30: return mk(OP_DIV,   R_T0,   R_DV,   R_AI,  '0);
      6'd31: return mk(OP_MIN,   R_ACC,  R_T0,   R_MA,  '0);
      6'd32: return mk(OP_NEG,   R_DEC,  R_ACC,  R_ACC, '0);
      6'd33: return mk(OP_SUB,   R_T0,   R_VC,   R_SV,  '0);
      6'd34: return mk(OP_DIV,   R_AI,   R_T0,   R_ACC, '0);
      6'd35: return mk(OP_ADD,   R_T0,   R_VC,   R_SV,  '0);
      6'd36: return mk(OP_MUL,   R_T0,   R_T0,   R_AI,  '0);
      6'd37: return mk(OP_HALF,  R_AD,   R_T0,   R_T0,  '0);
      6'd38: return mk(OP_SUB,   R_T0,   R_EV,   R_VC,  '0);
      6'd39: return mk(OP_DIV,   R_DI,   R_T0,   R_DEC, '0);
      6'd40: return mk(OP_ADD,   R_T0,   R_VC,   R_EV,  '0);
      6'd41: return mk(OP_MUL,   R_T0,   R_T0,   R_DI,  '0);
      6'd42: return mk(OP_HALF,  R_DD,   R_T0,   R_T0,  '0);
      6'd43: return mk(OP_SUB,   R_T0,   R_D,    R_AD,  '0);
      6'd44: return mk(OP_SUB,   R_CD,   R_T0,   R_DD,  '0);
      6'd45: return mk(OP_ADD,   R_TTC,  R_ST,   R_AI,  '0);
      6'd46: return mk(OP_ADD,   R_APOS, R_SP,   R_AD,  '0);
      6'd47: return mk(OP_JNTRI, R_T0,   R_CD,   R_CD,  L_TRAP);
      6'd48: return mk(OP_ADD,   R_FT,   R_TTC,  R_DI,  '0);
      6'd49: return mk(OP_ADD,   R_FP,   R_APOS, R_DD,  '0);
      6'd50: return mk(OP_SUB,   R_TOT,  R_FT,   R_ST,  '0);
      6'd51: return mk(OP_END2,  R_T0,   R_T0,   R_T0,  '0);
      6'd52: return mk(OP_DIV,   R_CI,   R_CD,   R_VC,  '0);
      6'd53: return mk(OP_ADD,   R_CT,   R_CI,   R_TTC, '0);
      6'd54: return mk(OP_ADD,   R_CP,   R_CD,   R_APOS, '0);
      6'd55: return mk(OP_ADD,   R_FT,   R_CT,   R_DI,  '0);
      6'd56: return mk(OP_ADD,   R_FP,   R_CP,   R_DD,  '0);
      6'd57: return mk(OP_SUB,   R_TOT,  R_FT,   R_ST,  '0);
      6'd58: return mk(OP_END3,  R_T0,   R_T0,   R_T0,  '0);
      default: return mk(OP_END2, R_T0,  R_T0,   R_T0,  '0);
    endcase
  endfunction

endpackage

FILE: src/tmp_req_if.sv
interface tmp_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_pos;
  logic signed [31:0] start_time;
  logic signed [31:0] start_vel;
  logic signed [31:0] end_pos;
  logic signed [31:0] end_time;
  logic signed [31:0] end_vel;
  logic               reversed;

  modport source (output valid, start_pos, start_time, start_vel, end_pos, end_time,
                  end_vel, reversed, input ready);
  modport sink (input valid, start_pos, start_time, start_vel, end_pos, end_time,
                end_vel, reversed, output ready);
endinterface

FILE: src/tmp_res_if.sv
interface tmp_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         seg_index;
  logic signed [31:0] seg_end_pos;
  logic signed [31:0] seg_end_time;
  logic signed [31:0] seg_end_vel;
  logic               seg_reversed;
  logic signed [31:0] total_time;
  logic               plan_error;
  logic               last;

  modport source (output valid, seg_index, seg_end_pos, seg_end_time, seg_end_vel,
                  seg_reversed, total_time, plan_error, last, input ready);
  modport sink (input valid, seg_index, seg_end_pos, seg_end_time, seg_end_vel,
                seg_reversed, total_time, plan_error, last, output ready);
endinterface

FILE: src/tmp_cfg_if.sv
interface tmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/trapezoid_motion_planner_core.sv
// Trapezoidal motion planner.
// req: one transfer per plan request (start and end setpoints, direction flag).
//   Requests are taken into a two-entry queue; distance and time span are
//   formed on entry, so the next request is accepted while one is being planned.
// res: two or three segment ends per request (accel end then decel end, or
//   accel, cruise and decel ends), or a single error transfer when a division by
//   zero or the root of a negative value occurs. last marks the final transfer.
// cfg: register writes (index 0 max_accel, index 1 max_vel); always ready,
//   other indexes are dropped. Write only while the planner is idle.
// Work per request: two to nine quotients from the shared one-bit-per-cycle
//   divider, where a zero divisor ends a quotient at once, plus one square root
//   from the root unit, and the steps of the sequencer.
// Reset: synchronous and active high; the queue empties, the sequencer goes
//   idle and both limits return to 1.0.
// Stall: the result register holds while res.ready is low; the sequencer
//   waits at the emit step and the queue keeps accepting until full.
module trapezoid_motion_planner_core #(
  parameter int FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  tmp_req_if.sink   req,
  tmp_res_if.source res,
  tmp_cfg_if.sink   cfg
);
  import tmp_pkg::*;

  localparam logic [30:0] ONE_Q = 31'd1 << FRAC_BITS;

  logic [30:0] max_accel;
  logic [30:0] max_vel;
  logic        head_valid;
  logic        pop;
  req_t        head;

  // limits accept a transfer every cycle
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel <= ONE_Q;
      max_vel   <= ONE_Q;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_MAX_ACCEL) max_accel <= cfg.data[30:0];
      if (cfg.index == CFG_MAX_VEL)   max_vel   <= cfg.data[30:0];
    end
  end

  // front: accept and queue requests
  tmp_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .head_valid(head_valid), .head(head), .pop(pop)
  );

  // back: run the plan program and hand out segment ends
  tmp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .max_accel(max_accel), .max_vel(max_vel),
    .head_valid(head_valid), .head(head), .pop(pop), .res(res)
  );
endmodule

FILE: src/tmp_ram.sv
module tmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

FILE: src/tmp_div.sv
module tmp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] q,
  output logic               dz
);
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num;
  logic [31:0]   rem;
  logic [31:0]   den;
  logic          neg;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   a_mag, b_mag;
  logic [32:0]   rem_sh;
  logic [33:0]   diff;
  logic          ge;

  assign a_mag  = a[31] ? 32'(0 - a) : a;
  assign b_mag  = b[31] ? 32'(0 - b) : b;
  assign rem_sh = {rem, num[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};
  assign ge     = !diff[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      dz   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (b == 0) begin
          done <= 1'b1;
          dz   <= 1'b1;
          num  <= '0;
          neg  <= 1'b0;
        end else begin
          busy <= 1'b1;
          dz   <= 1'b0;
          num  <= {a_mag, {FRAC_BITS{1'b0}}};
          den  <= b_mag;
          rem  <= '0;
          neg  <= a[31] ^ b[31];
          cnt  <= CW'(NW);
        end
      end else if (busy) begin
        rem <= ge ? diff[31:0] : rem_sh[31:0];
        num <= {num[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate the magnitude back into 32 signed bits
  always_comb begin
    if (neg) begin
      if (num > {{(NW-32){1'b0}}, 32'h8000_0000}) q = 32'sh8000_0000;
      else q = 32'(0 - num[31:0]);
    end else begin
      if (num > {{(NW-32){1'b0}}, 32'h7fff_ffff}) q = 32'sh7fff_ffff;
      else q = num[31:0];
    end
  end
endmodule

FILE: src/tmp_sqrt.sv
module tmp_sqrt #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] x,
  output logic               done,
  output logic signed [31:0] r_out,
  output logic               neg
);
  localparam int SQ_IT = (32 + FRAC_BITS) / 2;
  localparam int VW2   = 2 * SQ_IT;
  localparam int CW    = $clog2(SQ_IT + 1);

  logic [VW2-1:0] v, r, bt;
  logic [VW2-1:0] rb;
  logic           busy;
  logic [CW-1:0]  cnt;

  assign rb    = r + bt;
  assign r_out = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      neg  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r <= '0;
        if (x[31]) begin
          done <= 1'b1;
          neg  <= 1'b1;
        end else begin
          busy <= 1'b1;
          neg  <= 1'b0;
          v    <= {{(VW2-31){1'b0}}, x[30:0]} << FRAC_BITS;
          bt   <= {2'b01, {(VW2-2){1'b0}}};
          cnt  <= CW'(SQ_IT);
        end
      end else if (busy) begin
        if (v >= rb) begin
          v <= v - rb;
          r <= (r >> 1) + bt;
        end else begin
          r <= r >> 1;
        end
        bt  <= bt >> 2;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/tmp_front.sv
module tmp_front (
  input  logic          clk,
  input  logic          rst,
  tmp_req_if.sink       req,
  output logic          head_valid,
  output tmp_pkg::req_t head,
  input  logic          pop
);
  import tmp_pkg::*;

  req_t       ent [2];
  req_t       in_ent;
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push;

  assign req.ready  = (cnt != 2'd2);
  assign push       = req.valid && req.ready;
  assign head_valid = (cnt != 2'd0);
  assign head       = ent[rp];

  // work out the distance and time span on entry
  always_comb begin
    in_ent.sp  = req.start_pos;
    in_ent.st  = req.start_time;
    in_ent.sv  = req.start_vel;
    in_ent.ev  = req.end_vel;
    in_ent.d   = sat33({req.end_pos[31], req.end_pos} - {req.start_pos[31], req.start_pos});
    in_ent.ts  = sat33({req.end_time[31], req.end_time}
                       - {req.start_time[31], req.start_time});
    in_ent.rev = req.reversed;
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= in_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: src/tmp_back.sv
module tmp_back #(
  parameter int FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [30:0]   max_accel,
  input  logic [30:0]   max_vel,
  input  logic          head_valid,
  input  tmp_pkg::req_t head,
  output logic          pop,
  tmp_res_if.source     res
);
  import tmp_pkg::*;

  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [32:0] Q_TWO = 33'sd2 <<< FRAC_BITS;
  localparam logic signed [63:0] RND   = 64'(Q_ONE) - 64'sd1;

  state_t state, state_next;
  pc_t    pc;
  instr_t ins;
  req_t   job;
  logic [3:0] lc;
  logic [1:0] k;
  logic   n3, fault;
  logic signed [63:0] prod, adj, sh;
  logic signed [31:0] ra, rb, alu, mul_res, wdata;
  logic signed [32:0] ax, bx;
  logic   we;
  reg_addr_t waddr;
  logic   div_start, sqrt_start, div_done, sqrt_done, div_dz, sqrt_neg, unit_done;
  logic signed [31:0] div_q, sqrt_r;
  logic   taken, can_emit, last_item;
  logic signed [31:0] apos, ttc, vc, cp, ct, fp, ft, tot;
  logic   out_valid;
  reg_addr_t load_addr;
  logic signed [31:0] load_data;

  assign ins       = prog(pc);
  assign unit_done = (ins.op == OP_DIV) ? div_done : sqrt_done;
  assign can_emit  = !out_valid || res.ready;
  assign last_item = fault || (k == (n3 ? 2'd2 : 2'd1));
  assign res.valid = out_valid;

  tmp_ram #(.WIDTH(32), .DEPTH(REG_DEPTH)) u_regs (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ins.a), .raddr_b(ins.b), .rdata_a(ra), .rdata_b(rb)
  );

  tmp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(ra), .b(rb),
    .done(div_done), .q(div_q), .dz(div_dz)
  );

  tmp_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .x(ra),
    .done(sqrt_done), .r_out(sqrt_r), .neg(sqrt_neg)
  );

  always_comb begin
    unique case (lc)
      4'd0:    begin load_addr = R_SP;  load_data = job.sp; end
      4'd1:    begin load_addr = R_ST;  load_data = job.st; end
      4'd2:    begin load_addr = R_SV;  load_data = job.sv; end
      4'd3:    begin load_addr = R_EV;  load_data = job.ev; end
      4'd4:    begin load_addr = R_D;   load_data = job.d;  end
      4'd5:    begin load_addr = R_TS;  load_data = job.ts; end
      4'd6:    begin load_addr = R_MA;  load_data = {1'b0, max_accel}; end
      4'd7:    begin load_addr = R_MV;  load_data = {1'b0, max_vel};   end
      default: begin load_addr = R_ACC; load_data = {1'b0, max_accel}; end
    endcase
  end

  // simple operations and branch conditions
  always_comb begin
    ax    = {ra[31], ra};
    bx    = {rb[31], rb};
    alu   = ra;
    taken = 1'b0;
    unique case (ins.op)
      OP_ADD:   alu = sat33(ax + bx);
      OP_SUB:   alu = sat33(ax - bx);
      OP_MIN:   alu = (ra < rb) ? ra : rb;
      OP_HALF:  alu = 32'((ax + 33'(ra[31])) >>> 1);
      OP_NEG:   alu = sat33(33'sd0 - ax);
      OP_ADD2:  alu = sat33(ax + Q_TWO);
      OP_JZ:    taken = (ra == 0);
      OP_JGE:   taken = (ra >= rb);
      OP_JNTRI: taken = !((ra > -Q_ONE) && (ra < Q_ONE));
      OP_JMP:   taken = 1'b1;
      default:  alu = ra;
    endcase
  end

  // truncate the product toward zero, then saturate
  always_comb begin
    adj = prod + (prod[63] ? RND : 64'sd0);
    sh  = adj >>> FRAC_BITS;
    if (sh > 64'sh7fff_ffff) mul_res = 32'sh7fff_ffff;
    else if (sh < -64'sh8000_0000) mul_res = 32'sh8000_0000;
    else mul_res = sh[31:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (head_valid) state_next = S_LOAD;
      S_LOAD:  if (lc == 4'(LOAD_N - 1)) state_next = S_FETCH;
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        unique case (ins.op)
          OP_MUL:            state_next = S_MULW;
          OP_DIV, OP_SQRT:   state_next = S_WAIT;
          OP_END2, OP_END3:  state_next = S_EMIT;
          default:           state_next = S_FETCH;
        endcase
      end
      S_MULW:  state_next = S_FETCH;
      S_WAIT:  if (unit_done) state_next = S_FETCH;
      S_EMIT:  if (can_emit && last_item) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == S_IDLE) && head_valid;
    div_start  = (state == S_EXEC) && (ins.op == OP_DIV);
    sqrt_start = (state == S_EXEC) && (ins.op == OP_SQRT);
    we         = 1'b0;
    waddr      = ins.dst;
    wdata      = alu;
    unique case (state)
      S_LOAD: begin
        we    = 1'b1;
        waddr = load_addr;
        wdata = load_data;
      end
      S_EXEC: we = (ins.op == OP_ADD) || (ins.op == OP_SUB) || (ins.op == OP_MIN)
                   || (ins.op == OP_HALF) || (ins.op == OP_NEG) || (ins.op == OP_ADD2);
      S_MULW: begin
        we    = 1'b1;
        wdata = mul_res;
      end
      S_WAIT: begin
        we    = unit_done;
        wdata = (ins.op == OP_DIV) ? div_q : sqrt_r;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      lc        <= '0;
      k         <= '0;
      n3        <= 1'b0;
      fault     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_EMIT) && can_emit) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (head_valid) begin
          lc    <= '0;
          fault <= 1'b0;
        end
        S_LOAD: begin
          lc <= lc + 1'b1;
          pc <= '0;
        end
        S_EXEC: begin
          if ((ins.op == OP_END2) || (ins.op == OP_END3)) begin
            n3 <= (ins.op == OP_END3);
            k  <= '0;
          end else if (taken) begin
            pc <= ins.tgt;
          end else if ((ins.op != OP_MUL) && (ins.op != OP_DIV) && (ins.op != OP_SQRT)) begin
            pc <= pc + 1'b1;
          end
        end
        S_MULW: pc <= pc + 1'b1;
        S_WAIT: if (unit_done) begin
          pc <= pc + 1'b1;
          if ((ins.op == OP_DIV) ? div_dz : sqrt_neg) fault <= 1'b1;
        end
        S_EMIT: if (can_emit) begin
          k <= k + 1'b1;
        end
        default: pc <= pc;
      endcase
    end
  end

  // payload: job copy, product, shadows of the segment values, result register
  always_ff @(posedge clk) begin
    if (pop) job <= head;
    if ((state == S_EXEC) && (ins.op == OP_MUL)) prod <= ra * rb;
    if (we) begin
      if (waddr == R_APOS) apos <= wdata;
      if (waddr == R_TTC)  ttc  <= wdata;
      if (waddr == R_VC)   vc   <= wdata;
      if (waddr == R_CP)   cp   <= wdata;
      if (waddr == R_CT)   ct   <= wdata;
      if (waddr == R_FP)   fp   <= wdata;
      if (waddr == R_FT)   ft   <= wdata;
      if (waddr == R_TOT)  tot  <= wdata;
    end
    if ((state == S_EMIT) && can_emit) begin
      res.seg_reversed <= job.rev;
      res.plan_error   <= fault;
      res.last         <= last_item;
      if (fault) begin
        res.seg_index    <= 2'd0;
        res.seg_end_pos  <= '0;
        res.seg_end_time <= '0;
        res.seg_end_vel  <= '0;
        res.total_time   <= '0;
      end else begin
        res.seg_index  <= k;
        res.total_time <= tot;
        if (k == 2'd0) begin
          res.seg_end_pos  <= apos;
          res.seg_end_time <= ttc;
          res.seg_end_vel  <= vc;
        end else if ((k == 2'd1) && n3) begin
          res.seg_end_pos  <= cp;
          res.seg_end_time <= ct;
          res.seg_end_vel  <= vc;
        end else begin
          res.seg_end_pos  <= fp;
          res.seg_end_time <= ft;
          res.seg_end_vel  <= job.ev;
        end
      end
    end
  end

  a_div_done_waits: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WAIT))
    else $error("divider finished outside a wait");

  a_sqrt_done_waits: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == S_WAIT))
    else $error("root unit finished outside a wait");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_LOAD) && (lc == 4'd0))
    else $error("queue pop did not start a load");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && !fault && !n3) |-> (k <= 2'd1))
    else $error("too many segments for a triangular plan");
endmodule
